### hdl/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PPDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PPDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ppds_pkg.sv
package ppds_pkg;

   localparam int ALPHABET_DEF = 64;
   localparam int SUM_WIDTH_DEF = 32;
   localparam int PHONEME_W = 6;
   localparam int HIST = 4;
   localparam int COUNT_W = 8;
   localparam int CFG_W = 16;
   localparam int OUT_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 3 * OUT_W;
   localparam logic [CFG_W-1:0] FLOOR_RESET = 16'd5;
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

### hdl/ppds_ram.sv
module ppds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hdl/phoneme_pair_dictionary_score.sv
// Add item: one pair-table read and write per held history symbol (0..4), then a count update.
// Query item: one pair-table and count read per alphabet symbol, then a count update.
// Last item: the ratio is then formed by the bit-serial divider.
// One word at a time; the result register frees the input side.
// Reset: synchronous; all ALPHABET^2 pair-table entries (4096 by default) are
// swept to zero while req_tready stays low.
module phoneme_pair_dictionary_score #(
   parameter int ALPHABET  = ppds_pkg::ALPHABET_DEF,
   parameter int SUM_WIDTH = ppds_pkg::SUM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ppds_pkg::REQ_DATA_W-1:0]   req_tdata,  // phoneme, zero pad
   input  logic [0:0]                        req_tuser,  // mode
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ppds_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // overlap, ratio_q16,
                                                         // dictionary_weight_total
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppds_pkg::CFG_W-1:0]        csr_data
);

   localparam int IW    = $clog2(ALPHABET);
   localparam int NPAIR = ALPHABET * ALPHABET;
   localparam int PW    = $clog2(NPAIR);
   localparam int NW    = SUM_WIDTH + 16;
   localparam int DCW   = $clog2(NW + 1);
   localparam int PRW   = SUM_WIDTH + ppds_pkg::COUNT_W;
   localparam int PHW   = ppds_pkg::PHONEME_W;
   localparam int CW    = ppds_pkg::COUNT_W;
   localparam int OW    = ppds_pkg::OUT_W;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_ADD_RD   = 4'd2;
   localparam logic [3:0] S_ADD_WR   = 4'd3;
   localparam logic [3:0] S_Q_WALK   = 4'd4;
   localparam logic [3:0] S_Q_DRAIN  = 4'd5;
   localparam logic [3:0] S_UPD_RD   = 4'd6;
   localparam logic [3:0] S_UPD_WR   = 4'd7;
   localparam logic [3:0] S_DIV_INIT = 4'd8;
   localparam logic [3:0] S_DIV      = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

   function automatic logic [OW-1:0] clamp32(input logic [SUM_WIDTH-1:0] v);
      logic [SUM_WIDTH+OW-1:0] e;
      e = {{OW{1'b0}}, v};
      clamp32 = (e[SUM_WIDTH+OW-1:OW] != '0) ? {OW{1'b1}} : e[OW-1:0];
   endfunction

   function automatic logic [PW-1:0] pair_addr(input logic [IW-1:0] prev,
                                               input logic [PHW-1:0] ph);
      pair_addr = PW'(32'(prev) * ALPHABET + 32'(ph));
   endfunction

   // control
   logic [3:0]           state_ff, state_in;
   logic [2:0]           k_ff, k_in;
   logic [2:0]           rvalid_ff, rvalid_in;
   logic [ALPHABET-1:0]  cvalid_ff, cvalid_in;
   logic [SUM_WIDTH-1:0] total_ff, total_in;
   logic [SUM_WIDTH-1:0] overlap_ff, overlap_in;
   logic [ppds_pkg::CFG_W-1:0] floor_ff, floor_in;
   logic [PW-1:0]        clr_ff, clr_in;
   logic [IW-1:0]        qi_ff, qi_in;
   logic                 s1_v_ff, s1_v_in;
   logic                 prod_v_ff, prod_v_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // payload
   logic [PHW-1:0]       ph_ff, ph_in;
   logic                 last_ff, last_in;
   logic [PHW-1:0]       recent_ff [ppds_pkg::HIST];
   logic [PHW-1:0]       recent_in [ppds_pkg::HIST];
   logic                 s1_ok_ff, s1_ok_in;
   logic [PRW-1:0]       prod_ff, prod_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [SUM_WIDTH-1:0] rem_ff, rem_in;
   logic [SUM_WIDTH-1:0] den_ff, den_in;
   logic [ppds_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic                 pw_we;
   logic [PW-1:0]        pw_waddr, pw_raddr;
   logic [SUM_WIDTH-1:0] pw_wdata, pw_rdata;
   logic                 cnt_we;
   logic [IW-1:0]        cnt_waddr, cnt_raddr;
   logic [CW-1:0]        cnt_wdata, cnt_rdata;

   ppds_ram #(.WIDTH(SUM_WIDTH), .DEPTH(NPAIR)) u_pair_ram (
      .clock (clock),
      .we    (pw_we),
      .waddr (pw_waddr),
      .wdata (pw_wdata),
      .raddr (pw_raddr),
      .rdata (pw_rdata)
   );

   ppds_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   logic [IW-1:0]        ph_idx;
   logic [IW-1:0]        prev_idx;
   logic [SUM_WIDTH-1:0] w_add;
   logic [SUM_WIDTH:0]   pw_sum, tot_sum;
   logic [SUM_WIDTH+8:0] ov_sum;
   logic [CW-1:0]        cnt_cur;
   logic [SUM_WIDTH:0]   rem_sh;
   logic [SUM_WIDTH-1:0] den_sel;
   logic [OW-1:0]        ratio;

   assign ph_idx    = IW'(ph_ff);
   assign prev_idx  = IW'(recent_ff[k_ff[1:0]]);
   assign w_add     = SUM_WIDTH'(4'd8 >> k_ff[1:0]);
   assign pw_sum    = {1'b0, pw_rdata} + {1'b0, w_add};
   assign tot_sum   = {1'b0, total_ff} + {1'b0, w_add};
   assign ov_sum    = (SUM_WIDTH+9)'(overlap_ff) + (SUM_WIDTH+9)'(prod_ff);
   assign cnt_cur   = cvalid_ff[ph_idx] ? cnt_rdata : '0;
   assign rem_sh    = {rem_ff, num_ff[NW-1]};
   assign den_sel   = (total_ff > SUM_WIDTH'(floor_ff)) ? total_ff : SUM_WIDTH'(floor_ff);
   assign ratio     = (num_ff[NW-1:OW] != '0) ? {OW{1'b1}} : num_ff[OW-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rvalid_in    = rvalid_ff;
      cvalid_in    = cvalid_ff;
      total_in     = total_ff;
      overlap_in   = overlap_ff;
      floor_in     = floor_ff;
      clr_in       = clr_ff;
      qi_in        = qi_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      ph_in        = ph_ff;
      last_in      = last_ff;
      recent_in    = recent_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      rsp_data_in  = rsp_data_ff;
      pw_we        = 1'b0;
      pw_waddr     = '0;
      pw_wdata     = '0;
      pw_raddr     = '0;
      cnt_we       = 1'b0;
      cnt_waddr    = '0;
      cnt_wdata    = '0;
      cnt_raddr    = '0;

      // query multiply-accumulate pipe
      s1_v_in   = 1'b0;
      s1_ok_in  = 1'b0;
      prod_v_in = s1_v_ff;
      prod_in   = s1_ok_ff ? PRW'(cnt_rdata) * PRW'(pw_rdata) : '0;
      if (prod_v_ff) begin
         overlap_in = (ov_sum > (SUM_WIDTH+9)'(SUM_MAX)) ? SUM_MAX
                                                       : ov_sum[SUM_WIDTH-1:0];
      end

      if (csr_valid) begin
         floor_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            pw_we    = 1'b1;
            pw_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == PW'(NPAIR - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               ph_in   = req_tdata[PHW-1:0];
               last_in = req_tlast;
               k_in    = '0;
               qi_in   = '0;
               if (32'(req_tdata[PHW-1:0]) < ALPHABET) begin
                  if (req_tuser[0] == ppds_pkg::MODE_ADD) begin
                     state_in = (rvalid_ff != '0) ? S_ADD_RD : S_UPD_RD;
                  end else begin
                     state_in = S_Q_WALK;
                  end
               end else begin
                  state_in = req_tlast ? S_DIV_INIT : S_IDLE;
               end
            end
         end
         S_ADD_RD: begin
            pw_raddr = pair_addr(prev_idx, ph_ff);
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            pw_we    = 1'b1;
            pw_waddr = pair_addr(prev_idx, ph_ff);
            pw_wdata = pw_sum[SUM_WIDTH] ? SUM_MAX : pw_sum[SUM_WIDTH-1:0];
            total_in = tot_sum[SUM_WIDTH] ? SUM_MAX : tot_sum[SUM_WIDTH-1:0];
            k_in     = k_ff + 3'd1;
            state_in = (k_ff + 3'd1 == rvalid_ff) ? S_UPD_RD : S_ADD_RD;
         end
         S_Q_WALK: begin
            pw_raddr  = pair_addr(qi_ff, ph_ff);
            cnt_raddr = qi_ff;
            s1_v_in   = 1'b1;
            s1_ok_in  = cvalid_ff[qi_ff];
            qi_in     = qi_ff + 1'b1;
            if (qi_ff == IW'(ALPHABET - 1)) begin
               state_in = S_Q_DRAIN;
            end
         end
         S_Q_DRAIN: begin
            if (!s1_v_ff && !prod_v_ff) begin
               state_in = S_UPD_RD;
            end
         end
         S_UPD_RD: begin
            cnt_raddr = ph_idx;
            state_in  = S_UPD_WR;
         end
         S_UPD_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = ph_idx;
            cnt_wdata = (cnt_cur == {CW{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;
            cvalid_in[ph_idx] = 1'b1;
            for (int i = ppds_pkg::HIST - 1; i > 0; i--) begin
               recent_in[i] = recent_ff[i-1];
            end
            recent_in[0] = ph_ff;
            if (rvalid_ff != 3'(ppds_pkg::HIST)) begin
               rvalid_in = rvalid_ff + 3'd1;
            end
            state_in = last_ff ? S_DIV_INIT : S_IDLE;
         end
         S_DIV_INIT: begin
            den_in   = (den_sel == '0) ? SUM_WIDTH'(1) : den_sel;
            num_in   = {overlap_ff, 16'd0};
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = SUM_WIDTH'(rem_sh - {1'b0, den_ff});
               num_in = {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[SUM_WIDTH-1:0];
               num_in = {num_ff[NW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(NW - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {clamp32(total_ff), ratio, clamp32(overlap_ff)};
               rvalid_in    = '0;
               cvalid_in    = '0;
               overlap_in   = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         k_ff         <= '0;
         rvalid_ff    <= '0;
         cvalid_ff    <= '0;
         total_ff     <= '0;
         overlap_ff   <= '0;
         floor_ff     <= ppds_pkg::FLOOR_RESET;
         clr_ff       <= '0;
         qi_ff        <= '0;
         s1_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rvalid_ff    <= rvalid_in;
         cvalid_ff    <= cvalid_in;
         total_ff     <= total_in;
         overlap_ff   <= overlap_in;
         floor_ff     <= floor_in;
         clr_ff       <= clr_in;
         qi_ff        <= qi_in;
         s1_v_ff      <= s1_v_in;
         prod_v_ff    <= prod_v_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff       <= ph_in;
      last_ff     <= last_in;
      recent_ff   <= recent_in;
      s1_ok_ff    <= s1_ok_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hdl/ppds_checker.sv
`include "assert_macros.svh"

module ppds_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ppds_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   `PPDS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `PPDS_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_tready, "input open during table clear")
   `PPDS_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "second word taken while busy")
   `PPDS_ASSERT(a_zero_ratio, clock, reset, rsp_tvalid && (rsp_tdata[31:0] == 32'd0) |-> rsp_tdata[63:32] == 32'd0, "nonzero ratio with zero overlap")

endmodule

bind phoneme_pair_dictionary_score ppds_checker u_ppds_checker (.*);

### tb/tb_phoneme_pair_dictionary_score.sv
module tb_phoneme_pair_dictionary_score;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPH = 64;
   localparam longint unsigned SMAX = 64'hFFFF_FFFF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic       mode;
      logic [5:0] phoneme;
      logic       last;
   } phon_word_type;

   typedef struct packed {
      logic [31:0] total;
      logic [31:0] ratio;
      logic [31:0] overlap;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ppds_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ppds_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ppds_pkg::CFG_W-1:0] csr_data = '0;

   always #4 clock = ~clock;

   phoneme_pair_dictionary_score u_top (.*);

   // predictor state
   longint unsigned pair_w [NPH*NPH];
   longint unsigned dict_sum;
   logic [5:0] hist [4];
   int unsigned hist_n;
   int unsigned seen [NPH];
   longint unsigned run_ovl;
   longint unsigned floor_val;

   phon_word_type pending_words[$];
   score_type expected_scores[$];
   int errors = 0;
   int n_scores = 0;
   int idle_cycles = 0;
   bit calm = 0;
   bit rx_hold = 0;
   int rx_hold_cnt = 0;
   int n_queries = 0;
   bit tx_fire = 0;

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      if (a >= SMAX || b >= SMAX - a) return SMAX;
      return a + b;
   endfunction

   function automatic void clear_seq();
      hist_n = 0;
      foreach (seen[i]) seen[i] = 0;
      run_ovl = 0;
   endfunction

   function automatic void score_word(phon_word_type w);
      longint unsigned den, q, r, rat, wt;
      score_type s;
      if (w.mode == ppds_pkg::MODE_ADD) begin
         for (int i = 0; i < hist_n; i++) begin
            wt = 8 >> i;
            pair_w[hist[i]*NPH + w.phoneme] = sat_sum(pair_w[hist[i]*NPH + w.phoneme], wt);
            dict_sum = sat_sum(dict_sum, wt);
         end
      end else begin
         for (int i = 0; i < NPH; i++)
            if (seen[i] != 0)
               run_ovl = sat_sum(run_ovl, seen[i] * pair_w[i*NPH + w.phoneme]);
      end
      for (int i = 3; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = w.phoneme;
      if (hist_n < 4) hist_n++;
      if (seen[w.phoneme] < 255) seen[w.phoneme]++;
      if (!w.last) return;
      den = dict_sum > floor_val ? dict_sum : floor_val;
      if (den == 0) den = 1;
      q = run_ovl / den;
      r = run_ovl % den;
      rat = (q >= 65536) ? 64'hFFFF_FFFF : (q << 16) + (r << 16) / den;
      s.overlap = run_ovl[31:0];
      s.ratio = rat[31:0];
      s.total = dict_sum[31:0];
      expected_scores.push_back(s);
      clear_seq();
   endfunction

   // input handshake seen at the rising edge
   always @(posedge clock) tx_fire <= req_tvalid && req_tready;

   // driver
   int tx_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (tx_fire) begin
            score_word(pending_words.pop_front());
            if (!calm && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 5);
         end
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, pending_words[0].phoneme};
            req_tuser <= pending_words[0].mode;
            req_tlast <= pending_words[0].last;
         end else
            req_tvalid <= 1'b0;
      end
   end

   // receiver readiness
   int rx_gap = 0;
   always @(negedge clock) begin
      if (rx_hold_cnt > 0) begin
         rx_hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 5);
      end
   end

   // monitor
   always @(posedge clock) begin
      score_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            n_scores <= n_scores + 1;
            if (expected_scores.size() == 0) begin
               $display("%0t unexpected word %h", $time, got);
               errors = errors + 1;
            end else begin
               want = expected_scores.pop_front();
               if (got.overlap !== want.overlap) begin
                  $display("%0t overlap exp %h got %h", $time, want.overlap, got.overlap);
                  errors = errors + 1;
               end
               if (got.ratio !== want.ratio) begin
                  $display("%0t ratio exp %h got %h", $time, want.ratio, got.ratio);
                  errors = errors + 1;
               end
               if (got.total !== want.total) begin
                  $display("%0t total exp %h got %h", $time, want.total, got.total);
                  errors = errors + 1;
               end
            end
         end
         if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic push_word(bit md, int ph, bit lst);
      phon_word_type w;
      w.mode = md;
      w.phoneme = ph[5:0];
      w.last = lst;
      pending_words.push_back(w);
      if (md == ppds_pkg::MODE_QUERY) n_queries++;
   endtask

   task automatic drain();
      wait (pending_words.size() == 0 && !req_tvalid);
      wait (expected_scores.size() == 0);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_floor(logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      floor_val = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // dictionary-building sentence of add words over the first alpha phonemes
   task automatic push_sentence(int len, int alpha);
      for (int i = 0; i < len; i++)
         push_word(ppds_pkg::MODE_ADD, $urandom_range(0, alpha - 1), i == len - 1);
   endtask

   task automatic push_random_seq(int len, int alpha);
      for (int i = 0; i < len; i++)
         push_word($urandom_range(0, 3) != 0, $urandom_range(0, alpha - 1), i == len - 1);
   endtask

   initial begin
      int alpha;
      foreach (pair_w[i]) pair_w[i] = 0;
      dict_sum = 0;
      floor_val = ppds_pkg::FLOOR_RESET;
      clear_seq();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      push_word(ppds_pkg::MODE_ADD, 0, 1'b1);
      push_word(ppds_pkg::MODE_QUERY, 63, 1'b1);
      push_word(ppds_pkg::MODE_ADD, 0, 1'b0);
      push_word(ppds_pkg::MODE_ADD, 63, 1'b0);
      push_word(ppds_pkg::MODE_ADD, 21, 1'b0);
      push_word(ppds_pkg::MODE_ADD, 42, 1'b0);
      push_word(ppds_pkg::MODE_ADD, 63, 1'b1);
      push_word(ppds_pkg::MODE_QUERY, 0, 1'b0);
      push_word(ppds_pkg::MODE_QUERY, 63, 1'b0);
      push_word(ppds_pkg::MODE_ADD, 21, 1'b0);
      push_word(ppds_pkg::MODE_QUERY, 42, 1'b0);
      push_word(ppds_pkg::MODE_QUERY, 63, 1'b1);
      push_word(ppds_pkg::MODE_ADD, 5, 1'b0);
      push_word(ppds_pkg::MODE_QUERY, 5, 1'b1);
      drain();
      write_floor(16'd0);
      push_word(ppds_pkg::MODE_QUERY, 0, 1'b0);
      push_word(ppds_pkg::MODE_QUERY, 63, 1'b1);
      drain();
      write_floor(16'd1);
      // repeated queries of one phoneme build heavy overlap on a small dictionary
      for (int i = 0; i < 40; i++) push_word(ppds_pkg::MODE_QUERY, 63, i == 39);
      drain();
      write_floor(16'hFFFF);
      push_random_seq(8, 64);

      // random phases across floor settings
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_floor(ph == 5 ? 16'd1 : 16'($urandom_range(1, 65535)));
         if (ph == 5) calm = 1;
         for (int s = 0; s < 28; s++) begin
            alpha = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(2, 8);
            if ($urandom_range(0, 2) == 0) push_sentence($urandom_range(1, 12), alpha);
            else push_random_seq($urandom_range(1, 20), alpha);
         end
         if (ph == 2) begin
            rx_hold_cnt = 600;
            for (int s = 0; s < 8; s++)
               push_word(ppds_pkg::MODE_ADD, $urandom_range(0, 63), 1'b1);
         end
      end
      drain();
      $display("covered %0d scores, %0d query words, dictionary total %0d",
               n_scores, n_queries, dict_sum);
      if (errors == 0 && expected_scores.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

### phoneme_pair_dictionary_score.f
+incdir+hdl
hdl/ppds_pkg.sv
hdl/ppds_ram.sv
hdl/phoneme_pair_dictionary_score.sv
hdl/ppds_checker.sv
tb/tb_phoneme_pair_dictionary_score.sv
